### rtl/fpfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_pkg: shared types and codes for the fixed partition fit allocator
// Field widths, stream word layout, register indexes, policy and status codes.
// ----------------------------------------------------------------------------
package fpfa_pkg;

   // Item field widths
   localparam int SLOT_W     = 4;
   localparam int REQ_SIZE_W = 16;
   localparam int STATUS_W   = 2;
   localparam int DATA_W     = 24;   // slot + size, padded to whole bytes

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;
   localparam int MODE_W     = 2;
   localparam int COUNT_W    = 5;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type REG_FIT_MODE    = 1'd0;
   localparam csr_index_type REG_BLOCK_COUNT = 1'd1;

   // Item kinds (carried in req_tuser)
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_ALLOC = 1'b1;

   // Placement policies; the unused code behaves as first fit
   localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

   // Result status (carried in rsp_tuser)
   localparam logic [STATUS_W-1:0] ST_LOADED    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BEYOND    = 2'd3;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

endpackage

### rtl/fixed_partition_fit_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_core: fixed partition first/best/worst fit
// Partition size table with one comparator stepped over the entries per
// allocation request.
// ----------------------------------------------------------------------------
// Usage:
//   req_* is the input stream. req_tuser selects the kind of word: a load
//   writes one partition size, an allocate asks for a partition of at least
//   the given size. rsp_* returns exactly one word per input word: status in
//   rsp_tuser, chosen partition index and its former size in rsp_tdata.
//   csr_* writes fit_mode (index 0) and block_count (index 1); write them only
//   while the block is idle.
// Operation:
//   A load passes from acceptance through the S_FINISH state into the result
//   register. An allocation reads the table through a single registered memory
//   port, one partition per cycle, and compares it in one shared comparator;
//   it steps through S_SCAN over the active partition count, then S_FINISH.
//   req_tready is high only while no word is in progress, so a new word is not
//   taken until the previous one has left S_FINISH for the result register.
// Reset clears every valid bit of the table (every partition taken), fit_mode and
//   block_count, and empties the result register.
// A stalled receiver holds the result register; the next input word is still
//   accepted, and its result waits until the register is taken.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator_core #(
   parameter int NUM_PARTITIONS = 16,
   parameter int SIZE_BITS      = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // Input stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [fpfa_pkg::DATA_W-1:0]       req_tdata,   // [3:0] slot, [19:4] size
   input  logic                              req_tuser,   // [0] action
   // Result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [fpfa_pkg::DATA_W-1:0]       rsp_tdata,   // [3:0] chosen_slot, [19:4] chosen_size
   output logic [fpfa_pkg::STATUS_W-1:0]     rsp_tuser,   // [1:0] status
   // Configuration writes
   input  logic                              csr_we,
   input  logic [fpfa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fpfa_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import fpfa_pkg::*;

   localparam int IDX_W = $clog2(NUM_PARTITIONS);
   localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);
   localparam int CMP_W = (SIZE_BITS > REQ_SIZE_W) ? SIZE_BITS : REQ_SIZE_W;

   // Configuration registers
   logic [MODE_W-1:0]          fit_mode_ff;
   logic [COUNT_W-1:0]         block_count_ff;

   // Sequencer and item registers
   state_type                  state_ff, state_in;
   logic                       action_ff, action_in;
   logic [SLOT_W-1:0]          slot_ff, slot_in;
   logic [REQ_SIZE_W-1:0]      size_ff, size_in;
   logic [CNT_W-1:0]           scan_ff, scan_in;

   // Read pipeline stage
   logic                       rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]           rd_idx_ff, rd_idx_in;
   logic [SIZE_BITS-1:0]       mem_q_ff;
   logic                       vq_ff;

   // Running candidate
   logic                       found_ff, found_in;
   logic [IDX_W-1:0]           pick_ff, pick_in;
   logic [SIZE_BITS-1:0]       best_ff, best_in;

   // Partition table with per-entry valid bits (invalid reads as zero)
   logic [SIZE_BITS-1:0]       mem [NUM_PARTITIONS];
   logic [NUM_PARTITIONS-1:0]  valid_ff, valid_in;

   // Result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]          rsp_slot_ff, rsp_slot_in;
   logic [REQ_SIZE_W-1:0]      rsp_size_ff, rsp_size_in;

   logic                       req_fire;
   logic [CNT_W-1:0]           count_w;
   logic                       scan_go;
   logic [SIZE_BITS-1:0]       ent_size;
   logic                       ent_live;
   logic                       ent_fits;
   logic                       take;
   logic                       out_free;
   logic                       finish_go;
   logic                       load_ok;
   logic                       alloc_ok;
   logic                       load_wr;
   logic [IDX_W-1:0]           load_addr;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Active partition count, clipped to the table depth
   assign count_w = (32'(block_count_ff) > NUM_PARTITIONS) ? CNT_W'(NUM_PARTITIONS)
                                                           : CNT_W'(block_count_ff);

   assign scan_go = (state_ff == S_SCAN) && (scan_ff < count_w);

   // Shared compare unit on the word just read
   assign ent_size = vq_ff ? mem_q_ff : '0;
   assign ent_live = (ent_size != '0);
   assign ent_fits = CMP_W'(size_ff) <= CMP_W'(ent_size);

   always_comb begin
      case (fit_mode_ff)
         MODE_BEST:  take = ent_live && ent_fits && (!found_ff || (ent_size < best_ff));
         MODE_WORST: take = ent_live && (!found_ff || (ent_size > best_ff));
         default:    take = ent_live && ent_fits && !found_ff;
      endcase
   end

   // Completion checks
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign finish_go = (state_ff == S_FINISH) && out_free;
   assign load_ok   = 32'(slot_ff) < 32'(count_w);
   assign alloc_ok  = found_ff &&
                      ((fit_mode_ff != MODE_WORST) || (CMP_W'(size_ff) <= CMP_W'(best_ff)));
   assign load_wr   = finish_go && (action_ff == ACT_LOAD) && load_ok;
   assign load_addr = IDX_W'(slot_ff);

   // Sequencer next state
   always_comb begin
      state_in  = state_ff;
      action_in = action_ff;
      slot_in   = slot_ff;
      size_in   = size_ff;
      scan_in   = scan_ff;
      rd_vld_in = 1'b0;
      rd_idx_in = scan_ff[IDX_W-1:0];
      found_in  = found_ff;
      pick_in   = pick_ff;
      best_in   = best_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               action_in = req_tuser;
               slot_in   = req_tdata[SLOT_W-1:0];
               size_in   = req_tdata[SLOT_W +: REQ_SIZE_W];
               scan_in   = '0;
               found_in  = 1'b0;
               state_in  = (req_tuser == ACT_ALLOC) ? S_SCAN : S_FINISH;
            end
         end
         S_SCAN: begin
            rd_vld_in = scan_go;
            if (scan_go) begin
               scan_in = scan_ff + CNT_W'(1);
            end else begin
               state_in = S_FINISH;
            end
            if (rd_vld_ff && take) begin
               found_in = 1'b1;
               pick_in  = rd_idx_ff;
               best_in  = ent_size;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Table valid bits: load sets, allocation clears
   always_comb begin
      valid_in = valid_ff;
      if (load_wr) begin
         valid_in[load_addr] = 1'b1;
      end
      if (finish_go && (action_ff == ACT_ALLOC) && alloc_ok) begin
         valid_in[pick_ff] = 1'b0;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_size_in   = rsp_size_ff;
      if (finish_go) begin
         rsp_valid_in = 1'b1;
         rsp_slot_in  = '0;
         rsp_size_in  = '0;
         if (action_ff == ACT_LOAD) begin
            rsp_status_in = load_ok ? ST_LOADED : ST_BEYOND;
         end else if (alloc_ok) begin
            rsp_status_in = ST_ALLOCATED;
            rsp_slot_in   = SLOT_W'(pick_ff);
            rsp_size_in   = REQ_SIZE_W'(best_ff);
         end else begin
            rsp_status_in = ST_NO_FIT;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rd_vld_ff      <= 1'b0;
         found_ff       <= 1'b0;
         valid_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         fit_mode_ff    <= MODE_FIRST;
         block_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_FIT_MODE:    fit_mode_ff    <= csr_wdata[MODE_W-1:0];
               REG_BLOCK_COUNT: block_count_ff <= csr_wdata[COUNT_W-1:0];
               default:         ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      slot_ff       <= slot_in;
      size_ff       <= size_in;
      scan_ff       <= scan_in;
      rd_idx_ff     <= rd_idx_in;
      pick_ff       <= pick_in;
      best_ff       <= best_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_size_ff   <= rsp_size_in;
   end

   // Partition memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (load_wr) begin
         mem[load_addr] <= SIZE_BITS'(size_ff);
      end
      if (scan_go) begin
         mem_q_ff <= mem[scan_ff[IDX_W-1:0]];
         vq_ff    <= valid_ff[scan_ff[IDX_W-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {(DATA_W - SLOT_W - REQ_SIZE_W)'(0), rsp_size_ff, rsp_slot_ff};

endmodule

### rtl/fpfa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_checker: port-level checks for the partition fit allocator
// Watches the stream ports over time; attached to the core by bind.
// ----------------------------------------------------------------------------
module fpfa_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [fpfa_pkg::DATA_W-1:0]       rsp_tdata,  // [3:0] chosen_slot, [19:4] chosen_size
   input  logic [fpfa_pkg::STATUS_W-1:0]     rsp_tuser   // [1:0] status
);
   import fpfa_pkg::*;

   // A stalled result word holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // One word at a time: ready drops right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while a word is in progress");

   // Only an allocation carries an index and size
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_ALLOCATED) |-> (rsp_tdata == '0))
      else $error("nonzero payload on a result that allocated nothing");

   // Result register is empty right after reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind fixed_partition_fit_allocator_core fpfa_checker u_fpfa_checker (.*);

### verif/tb_fixed_partition_fit_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_partition_fit_allocator_core: self-checking bench for the allocator
// Drives load and allocate words under first, best, worst and the unused fit
// policy at several partition counts. A scoreboard keeps its own partition
// table, predicts every result word and compares it field by field. Both
// stream sides insert random idle cycles except in steady-flow phases.
// ----------------------------------------------------------------------------
module tb_fixed_partition_fit_allocator_core;
   import fpfa_pkg::*;

   localparam int NUM_PARTS    = 16;
   localparam int IDLE_LIMIT   = 2000;
   localparam int TAIL_CYCLES  = 30;
   localparam int RANDOM_WORDS = 525;
   localparam int MAX_REPORTS  = 30;

   // Unassigned policy code, expected to act as first fit
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [SLOT_W-1:0]     slot;
      logic [REQ_SIZE_W-1:0] size;
   } alloc_outcome_type;

   // Partition table predictor and queue of expected result words
   class partition_scoreboard;
      logic [REQ_SIZE_W-1:0] part_size [NUM_PARTS];
      logic [MODE_W-1:0]     fit_mode;
      logic [COUNT_W-1:0]    block_count;
      alloc_outcome_type     expected_q [$];
      int                    mismatches;
      int                    words_checked;

      function new();
         foreach (part_size[i]) part_size[i] = '0;
         fit_mode      = MODE_FIRST;
         block_count   = '0;
         mismatches    = 0;
         words_checked = 0;
      endfunction

      function int unsigned live_count();
         return (block_count > NUM_PARTS) ? NUM_PARTS : block_count;
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         if (idx == REG_FIT_MODE) begin
            fit_mode = value[MODE_W-1:0];
         end else begin
            block_count = value[COUNT_W-1:0];
         end
      endfunction

      // Update the table for one accepted word and queue its result
      function void note_request(logic act, logic [SLOT_W-1:0] slot,
                                 logic [REQ_SIZE_W-1:0] size);
         alloc_outcome_type outcome;
         int unsigned       limit;
         int unsigned       pick;
         bit                found;
         limit   = live_count();
         outcome = '0;
         pick    = 0;
         found   = 1'b0;
         if (act == ACT_LOAD) begin
            if (slot < limit) begin
               part_size[slot] = size;
               outcome.status  = ST_LOADED;
            end else begin
               outcome.status = ST_BEYOND;
            end
         end else begin
            for (int unsigned i = 0; i < limit; i++) begin
               // zero size means taken
               if (part_size[i] == '0) continue;
               if (fit_mode == MODE_WORST) begin
                  if (!found || part_size[i] > part_size[pick]) begin
                     pick  = i;
                     found = 1'b1;
                  end
               end else if (size <= part_size[i]) begin
                  if (fit_mode == MODE_BEST) begin
                     if (!found || part_size[i] < part_size[pick]) begin
                        pick  = i;
                        found = 1'b1;
                     end
                  end else begin
                     pick  = i;
                     found = 1'b1;
                     break;
                  end
               end
            end
            // worst fit only offers the largest entry
            if (found && fit_mode == MODE_WORST && size > part_size[pick]) found = 1'b0;
            if (found) begin
               outcome.status  = ST_ALLOCATED;
               outcome.slot    = pick[SLOT_W-1:0];
               outcome.size    = part_size[pick];
               part_size[pick] = '0;
            end else begin
               outcome.status = ST_NO_FIT;
            end
         end
         expected_q.push_back(outcome);
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task check_result(logic [STATUS_W-1:0] status, logic [DATA_W-1:0] data);
         alloc_outcome_type want;
         words_checked++;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("word %0d unexpected, status %0d data %h",
                                      words_checked, status, data));
            return;
         end
         want = expected_q.pop_front();
         if (status !== want.status)
            report_mismatch($sformatf("word %0d status %0d, want %0d",
                                      words_checked, status, want.status));
         if (data[SLOT_W-1:0] !== want.slot)
            report_mismatch($sformatf("word %0d chosen_slot %0d, want %0d",
                                      words_checked, data[SLOT_W-1:0], want.slot));
         if (data[SLOT_W+REQ_SIZE_W-1:SLOT_W] !== want.size)
            report_mismatch($sformatf("word %0d chosen_size %h, want %h", words_checked,
                                      data[SLOT_W+REQ_SIZE_W-1:SLOT_W], want.size));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata;    // [3:0] slot, [19:4] size
   logic                  req_tuser;    // [0] action
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [DATA_W-1:0]     rsp_tdata;    // [3:0] chosen_slot, [19:4] chosen_size
   logic [STATUS_W-1:0]   rsp_tuser;    // [1:0] status
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   partition_scoreboard sb;
   bit                  steady_flow = 1'b0;   // no idle cycles on either side
   int                  stall_cycles = 0;

   fixed_partition_fit_allocator_core #(
      .NUM_PARTITIONS (16),
      .SIZE_BITS      (16)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: too long without any word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == IDLE_LIMIT) begin
            $display("tb_fixed_partition_fit_allocator_core: FAIL");
            $finish;
         end
      end
   end

   // Result side: random stalls, check every accepted word
   initial begin : result_sink
      int gap;
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         gap = steady_flow ? 0 : $urandom_range(0, 4);
         @(negedge clock);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tuser, rsp_tdata);
      end
   end

   // Present one word after a random gap and hold it until accepted
   task automatic send_word(input logic act, input logic [SLOT_W-1:0] slot,
                            input logic [REQ_SIZE_W-1:0] size);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {{(DATA_W-SLOT_W-REQ_SIZE_W){1'b0}}, size, slot};
      do @(posedge clock); while (!req_tready);
      sb.note_request(act, slot, size);
   endtask

   // Stop sending and wait for every outstanding result
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Idle the block, then write both registers
   task automatic set_policy(input logic [MODE_W-1:0] mode,
                             input logic [COUNT_W-1:0] count);
      logic [CSR_DATA_W-1:0] mode_word;
      mode_word                = CSR_DATA_W'($urandom);   // upper bits are don't-care
      mode_word[MODE_W-1:0]    = mode;
      wait_drained();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= REG_FIT_MODE;
      csr_wdata <= mode_word;
      sb.write_register(REG_FIT_MODE, mode_word);
      @(negedge clock);
      csr_index <= REG_BLOCK_COUNT;
      csr_wdata <= count;
      sb.write_register(REG_BLOCK_COUNT, count);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly slots inside the active count, some beyond it
   function automatic logic [SLOT_W-1:0] pick_load_slot();
      int unsigned c;
      c = sb.live_count();
      if (c != 0 && $urandom_range(0, 7) != 0) return SLOT_W'($urandom_range(0, c - 1));
      return SLOT_W'($urandom);
   endfunction

   // Small sizes give plenty of ties; the rest covers the full range
   function automatic logic [REQ_SIZE_W-1:0] pick_load_size();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return REQ_SIZE_W'($urandom);
         default: return REQ_SIZE_W'($urandom_range(1, 64));
      endcase
   endfunction

   // Requests mostly near a live partition size, so fits and misses both occur
   function automatic logic [REQ_SIZE_W-1:0] pick_request_size();
      logic [REQ_SIZE_W-1:0] base;
      int unsigned           c;
      c = sb.live_count();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return REQ_SIZE_W'($urandom);
         default: begin
            base = (c == 0) ? '0 : sb.part_size[$urandom_range(0, c - 1)];
            if (base == '0) base = REQ_SIZE_W'($urandom_range(1, 64));
            case ($urandom_range(0, 2))
               0:       if (base != '0) base = base - 1'b1;
               1:       if (base != '1) base = base + 1'b1;
               default: ;
            endcase
            return base;
         end
      endcase
   endfunction

   initial begin
      int                 random_sent;
      int                 phase_len;
      logic [MODE_W-1:0]  mode;
      logic [COUNT_W-1:0] count;
      random_sent = 0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = ACT_LOAD;
      csr_we      = 1'b0;
      csr_index   = REG_FIT_MODE;
      csr_wdata   = '0;
      sb          = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset state: count zero, every partition taken
      send_word(ACT_LOAD, 4'd0, 16'd5);
      send_word(ACT_ALLOC, 4'd0, 16'd0);

      // First fit over all sixteen, extreme slots and sizes
      set_policy(MODE_FIRST, 5'd16);
      send_word(ACT_LOAD, 4'd0, 16'hFFFF);
      send_word(ACT_LOAD, 4'd15, 16'd1);
      send_word(ACT_LOAD, 4'd5, 16'd100);
      send_word(ACT_LOAD, 4'd6, 16'd100);
      send_word(ACT_LOAD, 4'd10, 16'h5555);
      send_word(ACT_LOAD, 4'd11, 16'hAAAA);
      send_word(ACT_ALLOC, 4'hF, 16'd0);      // zero request, slot field ignored
      send_word(ACT_ALLOC, 4'd0, 16'd100);
      send_word(ACT_ALLOC, 4'd0, 16'd100);
      send_word(ACT_ALLOC, 4'd0, 16'hFFFF);   // no fit

      // Best fit, count above the table size, tie on equal sizes
      set_policy(MODE_BEST, 5'd31);
      send_word(ACT_LOAD, 4'd3, 16'd50);
      send_word(ACT_LOAD, 4'd7, 16'd40);
      send_word(ACT_LOAD, 4'd9, 16'd40);
      send_word(ACT_ALLOC, 4'd0, 16'd40);
      send_word(ACT_ALLOC, 4'd0, 16'd40);
      send_word(ACT_ALLOC, 4'd0, 16'd41);
      send_word(ACT_ALLOC, 4'd0, 16'd0);

      // Worst fit with a single partition
      set_policy(MODE_WORST, 5'd1);
      send_word(ACT_LOAD, 4'd1, 16'd9);       // beyond count
      send_word(ACT_LOAD, 4'd0, 16'd7);
      send_word(ACT_ALLOC, 4'd0, 16'd8);
      send_word(ACT_ALLOC, 4'd0, 16'd7);

      // Unused policy code
      set_policy(MODE_UNUSED, 5'd16);
      send_word(ACT_ALLOC, 4'd0, 16'd2);

      // Random phases, each with its own policy and count
      while (random_sent < RANDOM_WORDS) begin
         phase_len = $urandom_range(20, 50);
         mode      = MODE_W'($urandom_range(0, 3));
         case ($urandom_range(0, 9))
            0:       count = COUNT_W'($urandom_range(17, 31));
            1:       count = 5'd16;
            2:       count = COUNT_W'($urandom_range(0, 2));
            default: count = COUNT_W'($urandom_range(3, 16));
         endcase
         set_policy(mode, count);
         steady_flow = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < phase_len; k++) begin
            if ($urandom_range(0, 59) == 0) wait_drained();
            if ($urandom_range(0, 99) < 45) begin
               send_word(ACT_LOAD, pick_load_slot(), pick_load_size());
            end else begin
               send_word(ACT_ALLOC, SLOT_W'($urandom), pick_request_size());
            end
            random_sent++;
         end
      end

      steady_flow = 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("tb_fixed_partition_fit_allocator_core: PASS");
      end else begin
         $display("tb_fixed_partition_fit_allocator_core: FAIL");
      end
      $finish;
   end

endmodule
